// ===== rtl/hpt_pkg.sv =====
// Shared types, constants and helpers for the homogeneous point transform.
// No dependencies; used by every file in rtl.
package hpt_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int REG_W     = 64;
    localparam int NUM_REGS  = 8;
    localparam int CFG_IDX_W = 4;
    // product shifted down, plus three-term and translation growth
    localparam int NUM_W     = 2 * DATA_W - FRAC_BITS + 2;
    localparam int DIV_STEPS = DATA_W;

    localparam logic [1:0] OP_POSITION  = 2'd0;
    localparam logic [1:0] OP_DIRECTION = 2'd1;
    localparam logic [1:0] OP_PERSP     = 2'd2;

    localparam logic [1:0] FAULT_OK     = 2'd0;
    localparam logic [1:0] FAULT_W_ZERO = 2'd1;
    localparam logic [1:0] FAULT_Z_ZERO = 2'd2;
    localparam logic [1:0] FAULT_SAT    = 2'd3;

    localparam logic [DATA_W-1:0] S32_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] S32_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] ONE_Q   = DATA_W'(1) << FRAC_BITS;

    localparam logic [REG_W-1:0] RST_DIAG_LO = {{DATA_W{1'b0}}, ONE_Q};
    localparam logic [REG_W-1:0] RST_DIAG_HI = {ONE_Q, {DATA_W{1'b0}}};

    typedef struct packed {
        logic [1:0]             op;
        logic                   wz;
        logic                   zz;
        logic                   sat;
        logic [2:0][DATA_W-1:0] val;
    } side_t;

    function automatic logic [DATA_W-1:0] sat_sign(input logic [NUM_W-1:0] n);
        logic [DATA_W-1:0] r;
        if (n == '0)
            r = '0;
        else if (n[NUM_W-1])
            r = S32_MIN;
        else
            r = S32_MAX;
        return r;
    endfunction

endpackage

// ===== rtl/hpt_div_pipe.sv =====
// Three-lane pipelined fixed-point divider, one quotient bit per stage,
// shared divisor. Depends on hpt_pkg.
module hpt_div_pipe (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  logic                                   in_vld,
    input  logic [2:0][hpt_pkg::NUM_W-1:0]         num,
    input  logic [hpt_pkg::NUM_W-1:0]              den,
    input  hpt_pkg::side_t                         in_side,
    output logic                                   out_vld,
    output logic [2:0][hpt_pkg::DATA_W-1:0]        res,
    output logic                                   sat,
    output hpt_pkg::side_t                         out_side
);

    localparam int NW = hpt_pkg::NUM_W;
    localparam int DW = hpt_pkg::DATA_W;
    localparam int NS = hpt_pkg::DIV_STEPS;

    logic [NS:0]            vld_reg;
    logic [2:0][NW-1:0]     rem_reg  [0:NS];
    logic [2:0][DW-1:0]     quo_reg  [0:NS];
    logic [2:0]             neg_reg  [0:NS];
    logic [2:0]             ovf_reg  [0:NS];
    logic [NW-1:0]          den_reg  [0:NS];
    hpt_pkg::side_t         side_reg [0:NS];

    logic [2:0][NW-1:0]     rem0_next;
    logic [2:0][DW-1:0]     quo0_next;
    logic [2:0][NW-1:0]     rem_next [1:NS];
    logic [2:0][DW-1:0]     quo_next [1:NS];
    logic [2:0]             neg_next;
    logic [2:0]             ovf_next;
    logic [NW-1:0]          dmag;

    logic                   out_vld_reg;
    logic [2:0][DW-1:0]     res_reg;
    logic [2:0][DW-1:0]     res_next;
    logic                   sat_reg;
    logic                   sat_next;
    hpt_pkg::side_t         out_side_reg;

    // prepare: magnitudes, sign, overflow test, initial partial remainder
    always_comb
    begin
        logic [NW-1:0]                      mag;
        logic [NW-1:0]                      hi;
        logic [NW+hpt_pkg::FRAC_BITS-1:0]   wide;
        dmag = den[NW-1] ? (~den + NW'(1)) : den;
        for (int k = 0; k < 3; k++)
        begin
            mag  = num[k][NW-1] ? (~num[k] + NW'(1)) : num[k];
            hi   = mag >> (DW - hpt_pkg::FRAC_BITS);
            wide = {mag, {hpt_pkg::FRAC_BITS{1'b0}}};
            neg_next[k]  = num[k][NW-1] ^ den[NW-1];
            ovf_next[k]  = (hi >= dmag);
            rem0_next[k] = hi;
            quo0_next[k] = wide[DW-1:0];
        end
    end

    // restoring step: low dividend bits shift out as quotient bits shift in
    always_comb
    begin
        logic [NW:0] t;
        logic [NW:0] diff;
        logic        ge;
        for (int s = 1; s <= NS; s++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                t    = {rem_reg[s-1][k], quo_reg[s-1][k][DW-1]};
                diff = t - {1'b0, den_reg[s-1]};
                ge   = (t >= {1'b0, den_reg[s-1]});
                rem_next[s][k] = ge ? diff[NW-1:0] : t[NW-1:0];
                quo_next[s][k] = {quo_reg[s-1][k][DW-2:0], ge};
            end
        end
    end

    always_comb
    begin
        logic [DW-1:0] q;
        logic          over;
        logic          lane_sat;
        sat_next = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            q        = quo_reg[NS][k];
            over     = neg_reg[NS][k] ? (q > hpt_pkg::S32_MIN) : q[DW-1];
            lane_sat = ovf_reg[NS][k] | over;
            sat_next = sat_next | lane_sat;
            if (lane_sat)
                res_next[k] = neg_reg[NS][k] ? hpt_pkg::S32_MIN : hpt_pkg::S32_MAX;
            else
                res_next[k] = neg_reg[NS][k] ? (DW'(0) - q) : q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg     <= {vld_reg[NS-1:0], in_vld};
            out_vld_reg <= vld_reg[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= rem0_next;
            quo_reg[0]  <= quo0_next;
            neg_reg[0]  <= neg_next;
            ovf_reg[0]  <= ovf_next;
            den_reg[0]  <= dmag;
            side_reg[0] <= in_side;
            for (int s = 1; s <= NS; s++)
            begin
                rem_reg[s]  <= rem_next[s];
                quo_reg[s]  <= quo_next[s];
                neg_reg[s]  <= neg_reg[s-1];
                ovf_reg[s]  <= ovf_reg[s-1];
                den_reg[s]  <= den_reg[s-1];
                side_reg[s] <= side_reg[s-1];
            end
            res_reg      <= res_next;
            sat_reg      <= sat_next;
            out_side_reg <= side_reg[NS];
        end
    end

    assign out_vld  = out_vld_reg;
    assign res      = res_reg;
    assign sat      = sat_reg;
    assign out_side = out_side_reg;

endmodule

// ===== rtl/homogeneous_point_transform.sv =====
// Pipeline: multiply, sum, two divider pipelines, output register.
// Throughput one point per cycle; the whole pipeline holds while the output is stalled.
// Divider depth is one quotient bit per stage, 32 stages per division.
// rst_n (async, active low) empties the pipeline and loads the identity matrix.
// Top level: matrix registers, products and sums; depends on hpt_pkg, hpt_div_pipe.
module homogeneous_point_transform (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [hpt_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [hpt_pkg::REG_W-1:0]             cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [1:0]                            operation,
    input  logic signed [hpt_pkg::DATA_W-1:0]     in_x,
    input  logic signed [hpt_pkg::DATA_W-1:0]     in_y,
    input  logic signed [hpt_pkg::DATA_W-1:0]     in_z,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [hpt_pkg::DATA_W-1:0]     out_x,
    output logic signed [hpt_pkg::DATA_W-1:0]     out_y,
    output logic signed [hpt_pkg::DATA_W-1:0]     out_z,
    output logic [1:0]                            fault
);

    localparam int NW = hpt_pkg::NUM_W;
    localparam int DW = hpt_pkg::DATA_W;

    logic [hpt_pkg::REG_W-1:0]  mat_reg [0:hpt_pkg::NUM_REGS-1];
    logic                       en;

    logic                       s1_vld_reg;
    logic [1:0]                 s1_op_reg;
    logic signed [2*DW-1:0]     prod_reg  [0:3][0:2];
    logic signed [2*DW-1:0]     prod_next [0:3][0:2];

    logic                       s2_vld_reg;
    logic [1:0]                 s2_op_reg;
    logic [3:0][NW-1:0]         num_reg;
    logic [3:0][NW-1:0]         num_next;

    hpt_pkg::side_t             side1_in;
    logic                       d1_vld;
    logic [2:0][DW-1:0]         res1;
    logic                       sat1;
    hpt_pkg::side_t             side1_out;

    hpt_pkg::side_t             side2_in;
    logic [2:0][NW-1:0]         num2;
    logic                       d2_vld;
    logic [2:0][DW-1:0]         res2;
    logic                       sat2;
    hpt_pkg::side_t             side2_out;

    logic                       out_valid_reg;
    logic [2:0][DW-1:0]         out_reg;
    logic [2:0][DW-1:0]         out_next;
    logic [1:0]                 fault_reg;
    logic [1:0]                 fault_next;

    function automatic logic [DW-1:0] ent(input logic [hpt_pkg::REG_W-1:0] r, input int c);
        return r[(c % 2) * DW +: DW];
    endfunction

    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_reg[0] <= hpt_pkg::RST_DIAG_LO;
            mat_reg[1] <= '0;
            mat_reg[2] <= hpt_pkg::RST_DIAG_HI;
            mat_reg[3] <= '0;
            mat_reg[4] <= '0;
            mat_reg[5] <= hpt_pkg::RST_DIAG_LO;
            mat_reg[6] <= '0;
            mat_reg[7] <= hpt_pkg::RST_DIAG_HI;
        end
        else if (cfg_write && (cfg_index < hpt_pkg::CFG_IDX_W'(hpt_pkg::NUM_REGS)))
        begin
            mat_reg[cfg_index[$clog2(hpt_pkg::NUM_REGS)-1:0]] <= cfg_data;
        end
    end

    // stage 1: twelve exact products, row k times column c
    always_comb
    begin
        logic signed [DW-1:0] v [0:2];
        v[0] = in_x;
        v[1] = in_y;
        v[2] = in_z;
        for (int c = 0; c < 4; c++)
            for (int k = 0; k < 3; k++)
                prod_next[c][k] = v[k] * $signed(ent(mat_reg[k*2 + c/2], c));
    end

    // stage 2: floor shift, sum, translation (always for w)
    always_comb
    begin
        logic signed [2*DW-1:0] sh;
        logic [NW-1:0]          acc;
        logic [DW-1:0]          tr;
        for (int c = 0; c < 4; c++)
        begin
            acc = '0;
            for (int k = 0; k < 3; k++)
            begin
                sh  = prod_reg[c][k] >>> hpt_pkg::FRAC_BITS;
                acc = acc + sh[NW-1:0];
            end
            tr = ent(mat_reg[6 + c/2], c);
            if (s1_op_reg != hpt_pkg::OP_DIRECTION || c == 3)
                acc = acc + NW'($signed(tr));
            num_next[c] = acc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg    <= in_valid;
            s2_vld_reg    <= s1_vld_reg;
            out_valid_reg <= d2_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_op_reg <= operation;
            prod_reg  <= prod_next;
            s2_op_reg <= s1_op_reg;
            num_reg   <= num_next;
            out_reg   <= out_next;
            fault_reg <= fault_next;
        end
    end

    always_comb
    begin
        side1_in.op  = s2_op_reg;
        side1_in.wz  = (num_reg[3] == '0);
        side1_in.zz  = 1'b0;
        side1_in.sat = 1'b0;
        for (int k = 0; k < 3; k++)
            side1_in.val[k] = hpt_pkg::sat_sign(num_reg[k]);
    end

    hpt_div_pipe u_div1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s2_vld_reg),
        .num      (num_reg[2:0]),
        .den      (num_reg[3]),
        .in_side  (side1_in),
        .out_vld  (d1_vld),
        .res      (res1),
        .sat      (sat1),
        .out_side (side1_out)
    );

    // second division by the saturated first-pass z
    always_comb
    begin
        side2_in.op  = side1_out.op;
        side2_in.wz  = side1_out.wz;
        side2_in.zz  = (res1[2] == '0);
        side2_in.sat = sat1;
        if (side1_out.wz)
            side2_in.val = side1_out.val;
        else if (side1_out.op == hpt_pkg::OP_PERSP && res1[2] == '0)
        begin
            side2_in.val[0] = hpt_pkg::sat_sign(NW'($signed(res1[0])));
            side2_in.val[1] = hpt_pkg::sat_sign(NW'($signed(res1[1])));
            side2_in.val[2] = '0;
        end
        else
            side2_in.val = res1;
        for (int k = 0; k < 3; k++)
            num2[k] = NW'($signed(res1[k]));
    end

    hpt_div_pipe u_div2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (d1_vld),
        .num      (num2),
        .den      (num2[2]),
        .in_side  (side2_in),
        .out_vld  (d2_vld),
        .res      (res2),
        .sat      (sat2),
        .out_side (side2_out)
    );

    always_comb
    begin
        if (side2_out.wz)
        begin
            out_next   = side2_out.val;
            fault_next = hpt_pkg::FAULT_W_ZERO;
        end
        else if (side2_out.op == hpt_pkg::OP_PERSP && side2_out.zz)
        begin
            out_next   = side2_out.val;
            fault_next = hpt_pkg::FAULT_Z_ZERO;
        end
        else if (side2_out.op == hpt_pkg::OP_PERSP)
        begin
            out_next   = res2;
            fault_next = (side2_out.sat | sat2) ? hpt_pkg::FAULT_SAT : hpt_pkg::FAULT_OK;
        end
        else
        begin
            out_next   = side2_out.val;
            fault_next = side2_out.sat ? hpt_pkg::FAULT_SAT : hpt_pkg::FAULT_OK;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_reg[0];
    assign out_y     = out_reg[1];
    assign out_z     = out_reg[2];
    assign fault     = fault_reg;

endmodule

// ===== rtl/hpt_checker.sv =====
// Port-level checks for the homogeneous point transform, bound to the top level.
// Depends on hpt_pkg.
module hpt_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic signed [hpt_pkg::DATA_W-1:0] out_x,
    input logic signed [hpt_pkg::DATA_W-1:0] out_y,
    input logic signed [hpt_pkg::DATA_W-1:0] out_z,
    input logic [1:0]                        fault
);

    // a held result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // input side stalls exactly when a result is held
    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall not tied to output hold");

    a_z_fault: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fault == hpt_pkg::FAULT_Z_ZERO |-> out_z == '0)
        else $error("z fault with nonzero z");

    a_w_fault: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fault == hpt_pkg::FAULT_W_ZERO |->
            (out_x == '0 || out_x == hpt_pkg::S32_MAX || out_x == hpt_pkg::S32_MIN))
        else $error("w fault without saturated x");

endmodule

bind homogeneous_point_transform hpt_checker u_hpt_checker (.*);
